[rtl/dtq_pkg.sv]
// dtq_pkg: shared types and constants for the deadline timer queue
// holds the beat structs, cell entry and control structs, and the op/status codes
// no dependencies
package dtq_pkg;

	localparam int TIME_BITS   = 48;
	localparam int TARGET_BITS = 16;
	localparam int MAX_RESULTS = 32;
	localparam int FIRE_BITS   = $clog2(MAX_RESULTS);

	// operation codes of an input beat
	typedef enum logic [2:0] {
		OP_SCHEDULE   = 3'd0,
		OP_CANCEL_ALL = 3'd1,
		OP_CANCEL_ONE = 3'd2,
		OP_RESCHEDULE = 3'd3,
		OP_TICK       = 3'd4
	} op_code_t;

	// status codes of a result beat
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NOT_FOUND  = 3'd1,
		ST_FULL       = 3'd2,
		ST_FIRED      = 3'd3,
		ST_NOTHING    = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]             operation;
		logic [TARGET_BITS-1:0] target;
		logic [TIME_BITS-1:0]   when;
		logic [TIME_BITS-1:0]   new_when;
	} op_item_t;

	typedef struct packed {
		logic [2:0]             status;
		logic [TARGET_BITS-1:0] fired_target;
		logic [TIME_BITS-1:0]   fired_time;
		logic                   last;
	} res_item_t;

	// one slot of the sorted table
	typedef struct packed {
		logic                   valid;
		logic [TIME_BITS-1:0]   due;
		logic [TARGET_BITS-1:0] owner;
	} entry_t;

	// what every cell does this cycle
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic                   use_time;
		logic [TIME_BITS-1:0]   key_time;
		logic [TARGET_BITS-1:0] key_target;
	} cell_ctl_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_CANCEL_ALL,
		S_CANCEL_ONE,
		S_RESCHED,
		S_RESCHED_INS,
		S_TICK,
		S_RESPOND
	} state_t;

endpackage

[rtl/dtq_cell.sv]
// dtq_cell: one slot of the sorted timer table
// shifts toward the tail on insert and toward the head on remove
// depends on dtq_pkg
module dtq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  dtq_pkg::cell_ctl_t ctl,
	input  dtq_pkg::entry_t   prev,
	input  logic              prev_gt,
	input  dtq_pkg::entry_t   next,
	input  logic              hit_in,
	output dtq_pkg::entry_t   entry,
	output logic              gt,
	output logic              hit_out
);
	import dtq_pkg::*;

	entry_t entry_q;
	entry_t entry_d;
	logic   match;
	logic   take_new;

	// compare against the broadcast key
	assign gt    = entry_q.valid && (entry_q.due > ctl.key_time);
	assign match = entry_q.valid && (entry_q.owner == ctl.key_target) &&
		(!ctl.use_time || (entry_q.due == ctl.key_time));
	assign hit_out = hit_in || match;

	// new entry lands in the first slot that is later or empty
	assign take_new = prev.valid && !prev_gt && (gt || !entry_q.valid);

	// next slot contents
	always_comb begin
		entry_d = entry_q;
		unique case (ctl.op)
			CELL_INSERT: begin
				if (prev_gt) begin
					entry_d = prev;
				end else if (take_new) begin
					entry_d.valid = 1'b1;
					entry_d.due   = ctl.key_time;
					entry_d.owner = ctl.key_target;
				end
			end
			CELL_REMOVE: begin
				if (hit_out) begin
					entry_d = next;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	// slot register, only the valid bit is reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q.valid <= 1'b0;
		end else begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;

endmodule

[rtl/deadline_timer_queue.sv]
// deadline_timer_queue: sorted table of deadlines held in a row of CAPACITY cells
// results: cancel-all removes one matching entry per cycle until none is left; a tick fires
// due entries off the head one per cycle while res_stall lets each result beat go
// one op at a time: a new op is accepted only once the controller is back in idle
// reset: arst_n clears every slot valid bit, the controller and the result valid
// depends on dtq_pkg and dtq_cell
module deadline_timer_queue #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_stall,
	input  dtq_pkg::op_item_t  op_item,
	output logic               res_valid,
	input  logic               res_stall,
	output dtq_pkg::res_item_t res_item
);
	import dtq_pkg::*;

	state_t    state_q, state_d;
	op_item_t  cmd_q;
	status_t   status_q, status_d;
	logic [FIRE_BITS-1:0] fire_cnt_q, fire_cnt_d;
	res_item_t res_q, res_d;
	logic      res_valid_q;
	logic      emit;
	logic      can_emit;
	logic      pop_head;
	cell_ctl_t ctl;
	cell_op_t  cell_op;
	logic      use_time;
	logic      head_due;
	logic      next_due;
	logic      fire_last;
	logic      table_full;
	logic      any_hit;

	entry_t ent [CAPACITY];
	logic   gt_c [CAPACITY];
	logic   hit_c [CAPACITY+1];

	localparam entry_t HEAD_GUARD = '{valid: 1'b1, due: '0, owner: '0};
	localparam entry_t TAIL_EMPTY = '{valid: 1'b0, due: '0, owner: '0};

	// broadcast control to the cell row
	assign ctl.op         = cell_op;
	assign ctl.use_time   = use_time;
	assign ctl.key_time   = (state_q == S_RESCHED_INS) ? cmd_q.new_when : cmd_q.when;
	assign ctl.key_target = cmd_q.target;
	assign hit_c[0]       = pop_head;

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t prev_e;
		logic   prev_g;
		entry_t next_e;
		if (i == 0) begin : g_head
			assign prev_e = HEAD_GUARD;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_e = ent[i-1];
			assign prev_g = gt_c[i-1];
		end
		if (i == CAPACITY-1) begin : g_tail
			assign next_e = TAIL_EMPTY;
		end else begin : g_body
			assign next_e = ent[i+1];
		end
		dtq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.prev    (prev_e),
			.prev_gt (prev_g),
			.next    (next_e),
			.hit_in  (hit_c[i]),
			.entry   (ent[i]),
			.gt      (gt_c[i]),
			.hit_out (hit_c[i+1])
		);
	end

	// table status seen by the controller
	assign table_full = ent[CAPACITY-1].valid;
	assign any_hit    = hit_c[CAPACITY];
	assign head_due   = ent[0].valid && (ent[0].due <= cmd_q.when);
	assign next_due   = ent[1].valid && (ent[1].due <= cmd_q.when);
	assign fire_last  = !next_due || (fire_cnt_q == FIRE_BITS'(MAX_RESULTS-1));
	assign can_emit   = !res_valid_q || !res_stall;

	// next state and outputs
	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		fire_cnt_d = fire_cnt_q;
		cell_op    = CELL_HOLD;
		use_time   = 1'b0;
		pop_head   = 1'b0;
		emit       = 1'b0;
		res_d      = '0;
		op_stall   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				op_stall = 1'b0;
				if (op_valid) begin
					fire_cnt_d = '0;
					case (op_item.operation)
						OP_SCHEDULE:   state_d = S_INSERT;
						OP_CANCEL_ALL: state_d = S_CANCEL_ALL;
						OP_CANCEL_ONE: state_d = S_CANCEL_ONE;
						OP_RESCHEDULE: state_d = S_RESCHED;
						OP_TICK:       state_d = S_TICK;
						default: begin
							status_d = ST_OK;
							state_d  = S_RESPOND;
						end
					endcase
				end
			end
			S_INSERT: begin
				if (table_full) begin
					status_d = ST_FULL;
				end else begin
					cell_op  = CELL_INSERT;
					status_d = ST_OK;
				end
				state_d = S_RESPOND;
			end
			S_CANCEL_ALL: begin
				// drop the first match each cycle until none is left
				cell_op = CELL_REMOVE;
				if (!any_hit) begin
					status_d = ST_OK;
					state_d  = S_RESPOND;
				end
			end
			S_CANCEL_ONE: begin
				cell_op  = CELL_REMOVE;
				use_time = 1'b1;
				status_d = ST_OK;
				state_d  = S_RESPOND;
			end
			S_RESCHED: begin
				cell_op  = CELL_REMOVE;
				use_time = 1'b1;
				if (any_hit) begin
					state_d = S_RESCHED_INS;
				end else begin
					status_d = ST_NOT_FOUND;
					state_d  = S_RESPOND;
				end
			end
			S_RESCHED_INS: begin
				cell_op  = CELL_INSERT;
				status_d = ST_OK;
				state_d  = S_RESPOND;
			end
			S_TICK: begin
				// pop due entries off the head one per cycle while the result register can take them
				if (!head_due) begin
					status_d = ST_NOTHING;
					state_d  = S_RESPOND;
				end else if (can_emit) begin
					cell_op            = CELL_REMOVE;
					pop_head           = 1'b1;
					emit               = 1'b1;
					res_d.status       = ST_FIRED;
					res_d.fired_target = ent[0].owner;
					res_d.fired_time   = ent[0].due;
					res_d.last         = fire_last;
					if (fire_last) begin
						state_d = S_IDLE;
					end else begin
						fire_cnt_d = fire_cnt_q + 1'b1;
					end
				end
			end
			S_RESPOND: begin
				if (can_emit) begin
					emit         = 1'b1;
					res_d.status = status_q;
					res_d.last   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fire_cnt_q <= '0;
			status_q   <= ST_OK;
		end else begin
			state_q    <= state_d;
			fire_cnt_q <= fire_cnt_d;
			status_q   <= status_d;
		end
	end

	// captured command beat
	always_ff @(posedge clk) begin
		if (op_valid && !op_stall) begin
			cmd_q <= op_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule
